// ----- hdl/apa_pkg.sv -----
package apa_pkg;

    localparam int APA_ACC_WIDTH   = 48;
    localparam int APA_TENSOR_FRAC = 16;

    localparam int TRIG_W   = 16;
    localparam int SCALE_W  = 24;
    localparam int TENSOR_W = 18;
    localparam int WEIGHT_W = 32;
    localparam int COEF_W   = 32;
    localparam int SUM_W    = 48;
    localparam int TERM_W   = 18;
    localparam int KIND_W   = 2;
    localparam int NTERMS   = 11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COS_ALPHA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_DELTA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COS_DELTA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SCALE = 3'd5;

    // weight modes
    localparam logic [1:0] WMODE_RAW    = 2'd1;
    localparam logic [1:0] WMODE_SCALED = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STAMP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALL   = 2'd2;

    // operands of the geometry program
    typedef enum logic [2:0] {
        OPD_XI1, OPD_XI2, OPD_ETA1, OPD_ETA2, OPD_ETA3, OPD_SD, OPD_SA
    } t_opnd;

    localparam logic [3:0] DEST_ETA1 = 4'd11;
    localparam logic [3:0] DEST_ETA2 = 4'd12;
    localparam int         GEO_STEPS = 17;

    typedef struct packed {
        t_opnd      opa;
        t_opnd      opb;
        logic       neg;
        logic       dbl;
        logic       store;
        logic [3:0] dest;
    } t_geo_op;

    // one multiply-accumulate per step; store closes a term
    function automatic t_geo_op geo_op(input logic [4:0] idx);
        t_geo_op op;
        case (idx)
            5'd0:    op = '{OPD_SD,   OPD_XI2,  1'b0, 1'b0, 1'b1, DEST_ETA1};
            5'd1:    op = '{OPD_SD,   OPD_SA,   1'b0, 1'b0, 1'b1, DEST_ETA2};
            5'd2:    op = '{OPD_XI1,  OPD_XI1,  1'b0, 1'b0, 1'b0, 4'd0};
            5'd3:    op = '{OPD_ETA1, OPD_ETA1, 1'b1, 1'b0, 1'b1, 4'd0};
            5'd4:    op = '{OPD_XI1,  OPD_XI2,  1'b0, 1'b1, 1'b0, 4'd1};
            5'd5:    op = '{OPD_ETA1, OPD_ETA2, 1'b1, 1'b1, 1'b1, 4'd1};
            5'd6:    op = '{OPD_ETA1, OPD_ETA3, 1'b1, 1'b1, 1'b1, 4'd2};
            5'd7:    op = '{OPD_XI2,  OPD_XI2,  1'b0, 1'b0, 1'b0, 4'd3};
            5'd8:    op = '{OPD_ETA2, OPD_ETA2, 1'b1, 1'b0, 1'b1, 4'd3};
            5'd9:    op = '{OPD_ETA2, OPD_ETA3, 1'b1, 1'b1, 1'b1, 4'd4};
            5'd10:   op = '{OPD_ETA3, OPD_ETA3, 1'b1, 1'b0, 1'b1, 4'd5};
            5'd11:   op = '{OPD_XI1,  OPD_ETA1, 1'b0, 1'b1, 1'b1, 4'd6};
            5'd12:   op = '{OPD_XI1,  OPD_ETA2, 1'b0, 1'b1, 1'b0, 4'd7};
            5'd13:   op = '{OPD_XI2,  OPD_ETA1, 1'b0, 1'b1, 1'b1, 4'd7};
            5'd14:   op = '{OPD_XI1,  OPD_ETA3, 1'b0, 1'b1, 1'b1, 4'd8};
            5'd15:   op = '{OPD_XI2,  OPD_ETA2, 1'b0, 1'b1, 1'b1, 4'd9};
            5'd16:   op = '{OPD_XI2,  OPD_ETA3, 1'b0, 1'b1, 1'b1, 4'd10};
            default: op = '{OPD_XI1,  OPD_XI1,  1'b0, 1'b0, 1'b0, 4'd0};
        endcase
        return op;
    endfunction

endpackage

// ----- hdl/apa_in_if.sv -----
interface apa_in_if import apa_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [TENSOR_W-1:0] tensor_xx;
    logic signed [TENSOR_W-1:0] tensor_xy;
    logic signed [TENSOR_W-1:0] tensor_xz;
    logic signed [TENSOR_W-1:0] tensor_yy;
    logic signed [TENSOR_W-1:0] tensor_yz;
    logic signed [TENSOR_W-1:0] tensor_zz;
    logic [WEIGHT_W-1:0]        noise_weight;
    logic                       end_of_detector;
    logic                       end_of_all;

    modport source (
        output valid, tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz, tensor_zz,
        output noise_weight, end_of_detector, end_of_all,
        input  ready
    );
    modport sink (
        input  valid, tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz, tensor_zz,
        input  noise_weight, end_of_detector, end_of_all,
        output ready
    );
endinterface

// ----- hdl/apa_out_if.sv -----
interface apa_out_if import apa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        result_kind;
    logic signed [COEF_W-1:0] a_weighted;
    logic signed [COEF_W-1:0] b_weighted;
    logic [SUM_W-1:0]         sum_aa;
    logic [SUM_W-1:0]         sum_bb;
    logic signed [SUM_W-1:0]  sum_ab;
    logic signed [SUM_W-1:0]  det_value;
    logic                     degenerate;
    logic                     last;

    modport source (
        output valid, result_kind, a_weighted, b_weighted, sum_aa, sum_bb, sum_ab,
        output det_value, degenerate, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, a_weighted, b_weighted, sum_aa, sum_bb, sum_ab,
        input  det_value, degenerate, last,
        output ready
    );
endinterface

// ----- hdl/antenna_pattern_accumulator.sv -----
// Antenna pattern accumulator.
// Input channel i_in carries one timestamp beat: six tensor components, a
// noise weight and the end-of-detector / end-of-all marks. Output channel
// o_out carries result beats: one timestamp beat per input, then a detector
// summary at end of detector, then a combined summary at end of all data;
// last marks the final beat caused by an input.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data. A write to
// one of the four trig registers while idle or in the geometry program reruns
// the geometry program (i_in.ready low meanwhile).
// One shared 33x33 multiplier, a one-step-per-cycle square root and a small
// sequencer do the work. In raw and scaled weight modes an input waits for a
// weight root (28-step root loop); unit-weight mode needs none. Each summary
// forms A*B - C*C from eight partial products.
// i_in.ready is high only while the sequencer is idle. A held output beat
// stalls the sequencer at its next result; the last beat may wait in the
// output register while the next input is taken.
// Synchronous reset clears the sums and geometry terms and loads register
// defaults; geometry terms stay zero until a trig register is written.
module antenna_pattern_accumulator import apa_pkg::*; #(
    parameter int ACC_WIDTH        = APA_ACC_WIDTH,
    parameter int TENSOR_FRAC_BITS = APA_TENSOR_FRAC
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    apa_in_if.sink                i_in,
    apa_out_if.source             o_out
);

    localparam int SHIFT_Q28 = TENSOR_FRAC_BITS - 13;
    localparam int SHR       = (SHIFT_Q28 > 0) ? SHIFT_Q28 : 0;
    localparam int SHL       = (SHIFT_Q28 < 0) ? -SHIFT_Q28 : 0;
    localparam int DOT_W     = 48;
    localparam logic signed [DOT_W-1:0] DOT_RND = (48'sd1 <<< SHR) >>> 1;
    localparam int GACC_W    = 40;
    localparam int DACC_W    = 130;
    localparam int ROOT_ITER = 28;
    localparam int ROOT_W    = 56;
    localparam int S_W       = 29;

    typedef enum logic [3:0] {
        S_IDLE, S_GEO, S_WMUL, S_DOT, S_ROOT, S_SCALE, S_SQ, S_TS, S_DET, S_FIN, S_SUMOUT
    } t_state;

    t_state r_state;
    logic [4:0] r_cnt;

    // configuration
    logic signed [TRIG_W-1:0] r_sin_a, r_cos_a, r_sin_d, r_cos_d;
    logic [1:0]               r_wmode;
    logic [SCALE_W-1:0]       r_wscale;

    // geometry
    logic signed [16:0]       r_eta1, r_eta2;
    logic signed [TERM_W-1:0] r_term [NTERMS];

    // current item
    logic signed [TENSOR_W-1:0] r_d [6];
    logic [WEIGHT_W-1:0]        r_nw;
    logic                       r_edet, r_eall;

    // datapath
    logic signed [65:0]        r_prod;
    logic signed [GACC_W-1:0]  r_gacc;
    logic signed [COEF_W-1:0]  r_a, r_b, r_aw, r_bw;
    logic [S_W-1:0]            r_s;
    logic signed [DACC_W-1:0]  r_dacc;
    logic signed [SUM_W-1:0]   r_det;
    logic                      r_deg;
    logic                      r_sel;

    // sums
    logic [ACC_WIDTH-1:0]        r_det_aa, r_det_bb, r_all_aa, r_all_bb;
    logic signed [ACC_WIDTH-1:0] r_det_ab, r_all_ab;

    // square root unit
    logic              r_sq_busy;
    logic [4:0]        r_sq_cnt;
    logic [ROOT_W-1:0] r_sq_x, r_sq_r, r_sq_bit;

    // output register
    logic                     r_o_valid, r_o_deg, r_o_last;
    logic [KIND_W-1:0]        r_o_kind;
    logic signed [COEF_W-1:0] r_o_aw, r_o_bw;
    logic [SUM_W-1:0]         r_o_aa, r_o_bb;
    logic signed [SUM_W-1:0]  r_o_ab, r_o_det;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -66'sd2147483648) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic logic signed [COEF_W-1:0] to_q28(input logic signed [DOT_W-1:0] v);
        logic signed [DOT_W-1:0] t;
        t = ((v + DOT_RND) >>> SHR) <<< SHL;
        return sat32(66'(t));
    endfunction

    function automatic logic [ACC_WIDTH-1:0] uadd(input logic [ACC_WIDTH-1:0] acc,
                                                  input logic [ACC_WIDTH-1:0] t);
        logic [ACC_WIDTH:0] s;
        s = {1'b0, acc} + {1'b0, t};
        return s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] sadd(
        input logic signed [ACC_WIDTH-1:0] acc, input logic signed [ACC_WIDTH-1:0] t);
        logic signed [ACC_WIDTH:0] s;
        s = (ACC_WIDTH+1)'(acc) + (ACC_WIDTH+1)'(t);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
            return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        return s[ACC_WIDTH-1:0];
    endfunction

    // geometry operands
    logic signed [16:0] w_xi1, w_xi2, w_eta3;
    assign w_xi1  = -17'(r_sin_a);
    assign w_xi2  = 17'(r_cos_a);
    assign w_eta3 = -17'(r_cos_d);

    function automatic logic signed [32:0] opnd(input t_opnd o, input logic signed [16:0] xi1,
        input logic signed [16:0] xi2, input logic signed [16:0] eta1,
        input logic signed [16:0] eta2, input logic signed [16:0] eta3,
        input logic signed [16:0] sd, input logic signed [16:0] sa);
        logic signed [16:0] v;
        unique case (o)
            OPD_XI1:  v = xi1;
            OPD_XI2:  v = xi2;
            OPD_ETA1: v = eta1;
            OPD_ETA2: v = eta2;
            OPD_ETA3: v = eta3;
            OPD_SD:   v = sd;
            OPD_SA:   v = sa;
            default:  v = '0;
        endcase
        return 33'(v);
    endfunction

    t_geo_op w_issue, w_cons;
    assign w_issue = geo_op(r_cnt);
    assign w_cons  = geo_op(r_cnt - 5'd1);

    // geometry accumulate and round
    logic signed [GACC_W-1:0] w_gp, w_gp2, w_gt, w_gsum, w_gr;
    logic signed [TERM_W-1:0] w_gterm;
    always_comb begin
        w_gp  = GACC_W'(r_prod);
        w_gp2 = w_cons.dbl ? (w_gp <<< 1) : w_gp;
        w_gt  = w_cons.neg ? -w_gp2 : w_gp2;
        w_gsum = r_gacc + w_gt;
        w_gr  = (w_gsum + 40'sd16384) >>> 15;
        if (w_gr > 40'sd131071)       w_gterm = 18'sh1FFFF;
        else if (w_gr < -40'sd131072) w_gterm = 18'sh20000;
        else                          w_gterm = TERM_W'(w_gr);
    end

    // dot product accumulate
    logic signed [GACC_W-1:0] w_dsum;
    logic [2:0]               w_di;
    assign w_dsum = r_gacc + GACC_W'(r_prod);
    assign w_di   = (r_cnt < 5'd6) ? r_cnt[2:0] : 3'(r_cnt - 5'd6);

    // summary operands
    logic [ACC_WIDTH-1:0]        w_xa, w_xb;
    logic signed [ACC_WIDTH-1:0] w_xab;
    logic [63:0]                 w_ua, w_ub, w_uc;
    logic signed [63:0]          w_ab64;
    always_comb begin
        w_xa   = r_sel ? r_all_aa : r_det_aa;
        w_xb   = r_sel ? r_all_bb : r_det_bb;
        w_xab  = r_sel ? r_all_ab : r_det_ab;
        w_ua   = 64'(w_xa);
        w_ub   = 64'(w_xb);
        w_ab64 = 64'(w_xab);
        w_uc   = w_ab64[63] ? (64'd0 - w_ab64) : w_ab64;
    end

    // determinant partial-product accumulate
    logic [2:0]               w_j;
    logic [DACC_W-1:0]        w_pp, w_pps;
    logic signed [DACC_W-1:0] w_dterm, w_dnext, w_drnd;
    logic                     w_dpos;
    logic signed [SUM_W-1:0]  w_dsat;
    always_comb begin
        w_j  = 3'(r_cnt - 5'd1);
        w_pp = DACC_W'(r_prod[63:0]);
        case (w_j[1:0])
            2'd0:    w_pps = w_pp;
            2'd3:    w_pps = w_pp << 64;
            default: w_pps = w_pp << 32;
        endcase
        w_dterm = w_j[2] ? -$signed(w_pps) : $signed(w_pps);
        w_dnext = r_dacc + w_dterm;
        w_dpos  = !r_dacc[DACC_W-1] && (r_dacc != '0);
        w_drnd  = (r_dacc + (130'sd1 <<< 23)) >>> 24;
        w_dsat  = (w_drnd[DACC_W-1:47] != '0) ? 48'sh7FFF_FFFF_FFFF : SUM_W'(w_drnd);
    end

    // summary field saturation
    logic [SUM_W-1:0]        w_oaa, w_obb;
    logic signed [SUM_W-1:0] w_oab;
    always_comb begin
        w_oaa = (w_ua[63:48] != '0) ? {SUM_W{1'b1}} : w_ua[47:0];
        w_obb = (w_ub[63:48] != '0) ? {SUM_W{1'b1}} : w_ub[47:0];
        if (w_ab64 > 64'sh0000_7FFF_FFFF_FFFF)       w_oab = 48'sh7FFF_FFFF_FFFF;
        else if (w_ab64 < -64'sh0000_8000_0000_0000) w_oab = 48'sh8000_0000_0000;
        else                                         w_oab = SUM_W'(w_ab64);
    end

    // square and cross terms
    logic [63:0]              w_sqr;
    logic signed [65:0]       w_abt, w_scl;
    assign w_sqr = (r_prod[63:0] + 64'h8000_0000) >> 32;
    assign w_abt = (r_prod + 66'sd2147483648) >>> 32;
    assign w_scl = (r_prod + 66'sd32768) >>> 16;

    // square root step
    logic [ROOT_W:0]   w_trial;
    logic              w_take;
    logic [ROOT_W-1:0] w_rnext;
    always_comb begin
        w_trial = {1'b0, r_sq_r} + {1'b0, r_sq_bit};
        w_take  = {1'b0, r_sq_x} >= w_trial;
        w_rnext = w_take ? ((r_sq_r >> 1) + r_sq_bit) : (r_sq_r >> 1);
    end

    // shared multiplier operand select
    logic signed [32:0] w_ma, w_mb;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_GEO: begin
                w_ma = opnd(w_issue.opa, w_xi1, w_xi2, r_eta1, r_eta2, w_eta3,
                            17'(r_sin_d), 17'(r_sin_a));
                w_mb = opnd(w_issue.opb, w_xi1, w_xi2, r_eta1, r_eta2, w_eta3,
                            17'(r_sin_d), 17'(r_sin_a));
            end
            S_WMUL: begin
                w_ma = $signed({1'b0, r_nw});
                w_mb = $signed({9'b0, r_wscale});
            end
            S_DOT: begin
                if (r_cnt <= 5'd10) begin
                    w_ma = 33'(r_d[w_di]);
                    w_mb = 33'(r_term[r_cnt[3:0]]);
                end
            end
            S_SCALE: begin
                w_ma = (r_cnt == 5'd0) ? 33'(r_a) : 33'(r_b);
                w_mb = $signed({4'b0, r_s});
            end
            S_SQ: begin
                case (r_cnt)
                    5'd0:    begin w_ma = 33'(r_aw); w_mb = 33'(r_aw); end
                    5'd1:    begin w_ma = 33'(r_bw); w_mb = 33'(r_bw); end
                    default: begin w_ma = 33'(r_aw); w_mb = 33'(r_bw); end
                endcase
            end
            S_DET: begin
                case (r_cnt[2:0])
                    3'd0: begin w_ma = {1'b0, w_ua[31:0]};  w_mb = {1'b0, w_ub[31:0]};  end
                    3'd1: begin w_ma = {1'b0, w_ua[31:0]};  w_mb = {1'b0, w_ub[63:32]}; end
                    3'd2: begin w_ma = {1'b0, w_ua[63:32]}; w_mb = {1'b0, w_ub[31:0]};  end
                    3'd3: begin w_ma = {1'b0, w_ua[63:32]}; w_mb = {1'b0, w_ub[63:32]}; end
                    3'd4: begin w_ma = {1'b0, w_uc[31:0]};  w_mb = {1'b0, w_uc[31:0]};  end
                    3'd5: begin w_ma = {1'b0, w_uc[31:0]};  w_mb = {1'b0, w_uc[63:32]}; end
                    3'd6: begin w_ma = {1'b0, w_uc[63:32]}; w_mb = {1'b0, w_uc[31:0]};  end
                    default: begin w_ma = {1'b0, w_uc[63:32]}; w_mb = {1'b0, w_uc[63:32]}; end
                endcase
            end
            default: ;
        endcase
    end

    logic w_geo_wr, w_out_free, w_accept;
    assign w_geo_wr = i_cfg_we && ((i_cfg_idx == REG_SIN_ALPHA) || (i_cfg_idx == REG_COS_ALPHA)
                      || (i_cfg_idx == REG_SIN_DELTA) || (i_cfg_idx == REG_COS_DELTA));
    assign w_out_free = !r_o_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && !w_geo_wr;
    assign w_accept   = i_in.valid && i_in.ready;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_sin_a   <= '0;
            r_cos_a   <= 16'sd32767;
            r_sin_d   <= '0;
            r_cos_d   <= 16'sd32767;
            r_wmode   <= '0;
            r_wscale  <= 24'd65536;
            r_eta1    <= '0;
            r_eta2    <= '0;
            for (int i = 0; i < NTERMS; i++) r_term[i] <= '0;
            r_det_aa  <= '0;
            r_det_bb  <= '0;
            r_det_ab  <= '0;
            r_all_aa  <= '0;
            r_all_bb  <= '0;
            r_all_ab  <= '0;
            r_gacc    <= '0;
            r_sq_busy <= 1'b0;
            r_sq_cnt  <= '0;
            r_o_valid <= 1'b0;
            r_sel     <= 1'b0;
        end else begin
            // drop the output beat once taken
            if (o_out.ready) r_o_valid <= 1'b0;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SIN_ALPHA:    r_sin_a  <= TRIG_W'(i_cfg_data);
                    REG_COS_ALPHA:    r_cos_a  <= TRIG_W'(i_cfg_data);
                    REG_SIN_DELTA:    r_sin_d  <= TRIG_W'(i_cfg_data);
                    REG_COS_DELTA:    r_cos_d  <= TRIG_W'(i_cfg_data);
                    REG_WEIGHT_MODE:  r_wmode  <= i_cfg_data[1:0];
                    REG_WEIGHT_SCALE: r_wscale <= i_cfg_data;
                    default: ;
                endcase
            end

            // advance the root loop
            if (r_sq_busy) begin
                if (r_sq_cnt != '0) begin
                    if (w_take) r_sq_x <= r_sq_x - w_trial[ROOT_W-1:0];
                    r_sq_r   <= w_rnext;
                    r_sq_bit <= r_sq_bit >> 2;
                    r_sq_cnt <= r_sq_cnt - 5'd1;
                end else begin
                    r_sq_busy <= 1'b0;
                    r_s       <= r_sq_r[S_W-1:0];
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_d[0] <= i_in.tensor_xx;
                        r_d[1] <= i_in.tensor_xy;
                        r_d[2] <= i_in.tensor_xz;
                        r_d[3] <= i_in.tensor_yy;
                        r_d[4] <= i_in.tensor_yz;
                        r_d[5] <= i_in.tensor_zz;
                        r_nw   <= i_in.noise_weight;
                        r_edet <= i_in.end_of_detector || i_in.end_of_all;
                        r_eall <= i_in.end_of_all;
                        r_state <= S_WMUL;
                    end
                end
                S_GEO: begin
                    if (r_cnt != '0) begin
                        if (w_cons.store) begin
                            r_gacc <= '0;
                            unique case (w_cons.dest)
                                DEST_ETA1: r_eta1 <= 17'(w_gr);
                                DEST_ETA2: r_eta2 <= 17'(w_gr);
                                default:   r_term[w_cons.dest] <= w_gterm;
                            endcase
                        end else begin
                            r_gacc <= w_gsum;
                        end
                    end
                    if (r_cnt == 5'(GEO_STEPS)) r_state <= S_IDLE;
                    r_cnt <= r_cnt + 5'd1;
                end
                S_WMUL: begin
                    r_gacc  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DOT;
                end
                S_DOT: begin
                    if (r_cnt == '0) begin
                        // start the weight root, or use unit scale when no root is needed
                        if (r_wmode == WMODE_RAW) begin
                            r_sq_x    <= {8'b0, r_nw, 16'b0};
                            r_sq_busy <= 1'b1;
                        end else if (r_wmode == WMODE_SCALED) begin
                            r_sq_x    <= r_prod[ROOT_W-1:0];
                            r_sq_busy <= 1'b1;
                        end else begin
                            r_s <= S_W'(65536);
                        end
                        r_sq_r   <= '0;
                        r_sq_bit <= ROOT_W'(1) << (2 * ROOT_ITER - 2);
                        r_sq_cnt <= 5'(ROOT_ITER);
                    end else if (r_cnt == 5'd6) begin
                        r_a    <= to_q28(DOT_W'(w_dsum));
                        r_gacc <= '0;
                    end else if (r_cnt == 5'd11) begin
                        r_b    <= to_q28(DOT_W'(w_dsum));
                        r_gacc <= '0;
                    end else begin
                        r_gacc <= w_dsum;
                    end
                    if (r_cnt == 5'd11) r_state <= S_ROOT;
                    r_cnt <= r_cnt + 5'd1;
                end
                S_ROOT: begin
                    if (!r_sq_busy) begin
                        r_cnt   <= '0;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (r_cnt == 5'd1) r_aw <= sat32(w_scl);
                    if (r_cnt == 5'd2) begin
                        r_bw    <= sat32(w_scl);
                        r_state <= S_SQ;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SQ: begin
                    if (r_cnt == 5'd1) r_det_aa <= uadd(r_det_aa, ACC_WIDTH'(w_sqr[31:0]));
                    if (r_cnt == 5'd2) r_det_bb <= uadd(r_det_bb, ACC_WIDTH'(w_sqr[31:0]));
                    if (r_cnt == 5'd3) begin
                        r_det_ab <= sadd(r_det_ab, ACC_WIDTH'(w_abt));
                        r_state  <= S_TS;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_TS: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= KIND_STAMP;
                        r_o_aw    <= r_aw;
                        r_o_bw    <= r_bw;
                        r_o_aa    <= '0;
                        r_o_bb    <= '0;
                        r_o_ab    <= '0;
                        r_o_det   <= '0;
                        r_o_deg   <= 1'b0;
                        r_o_last  <= !r_edet;
                        r_sel     <= 1'b0;
                        r_dacc    <= '0;
                        r_cnt     <= '0;
                        r_state   <= r_edet ? S_DET : S_IDLE;
                    end
                end
                S_DET: begin
                    if (r_cnt != '0) r_dacc <= w_dnext;
                    if (r_cnt == 5'd8) r_state <= S_FIN;
                    r_cnt <= r_cnt + 5'd1;
                end
                S_FIN: begin
                    r_det   <= w_dpos ? w_dsat : '0;
                    r_deg   <= !w_dpos;
                    r_state <= S_SUMOUT;
                end
                S_SUMOUT: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= r_sel ? KIND_ALL : KIND_DET;
                        r_o_aw    <= '0;
                        r_o_bw    <= '0;
                        r_o_aa    <= w_oaa;
                        r_o_bb    <= w_obb;
                        r_o_ab    <= w_oab;
                        r_o_det   <= r_det;
                        r_o_deg   <= r_deg;
                        r_o_last  <= r_sel || !r_eall;
                        r_dacc    <= '0;
                        r_cnt     <= '0;
                        if (!r_sel) begin
                            // fold the detector into the combined sums
                            r_all_aa <= uadd(r_all_aa, r_det_aa);
                            r_all_bb <= uadd(r_all_bb, r_det_bb);
                            r_all_ab <= sadd(r_all_ab, r_det_ab);
                            r_det_aa <= '0;
                            r_det_bb <= '0;
                            r_det_ab <= '0;
                            r_sel    <= 1'b1;
                            r_state  <= r_eall ? S_DET : S_IDLE;
                        end else begin
                            r_all_aa <= '0;
                            r_all_bb <= '0;
                            r_all_ab <= '0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // restart the geometry program on a trig write while idle or in the geometry program
            if (w_geo_wr && ((r_state == S_IDLE) || (r_state == S_GEO))) begin
                r_state <= S_GEO;
                r_cnt   <= '0;
                r_gacc  <= '0;
            end
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.result_kind = r_o_kind;
    assign o_out.a_weighted  = r_o_aw;
    assign o_out.b_weighted  = r_o_bw;
    assign o_out.sum_aa      = r_o_aa;
    assign o_out.sum_bb      = r_o_bb;
    assign o_out.sum_ab      = r_o_ab;
    assign o_out.det_value   = r_o_det;
    assign o_out.degenerate  = r_o_deg;
    assign o_out.last        = r_o_last;

endmodule

// ----- hdl/apa_check.sv -----
module apa_check import apa_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [KIND_W-1:0]       i_kind,
    input logic signed [COEF_W-1:0] i_aw,
    input logic signed [COEF_W-1:0] i_bw,
    input logic [SUM_W-1:0]        i_aa,
    input logic signed [SUM_W-1:0] i_det,
    input logic                    i_deg,
    input logic                    i_last
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // timestamp beats carry no sums
    a_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_STAMP) |-> (i_aa == '0) && (i_det == '0) && !i_deg)
        else $error("timestamp beat carries summary fields");

    // summary beats carry no coefficients
    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind != KIND_STAMP) |-> (i_aw == '0) && (i_bw == '0))
        else $error("summary beat carries coefficients");

    // degenerate matrix reports zero determinant
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_deg |-> (i_det == '0))
        else $error("degenerate beat with nonzero determinant");

    // combined summary always closes its input
    a_all_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_ALL) |-> i_last)
        else $error("combined summary without last");

endmodule

bind antenna_pattern_accumulator apa_check u_apa_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.result_kind),
    .i_aw        (o_out.a_weighted),
    .i_bw        (o_out.b_weighted),
    .i_aa        (o_out.sum_aa),
    .i_det       (o_out.det_value),
    .i_deg       (o_out.degenerate),
    .i_last      (o_out.last)
);
